FILE: src/bbd_pkg.sv
// Package for the block background difference design.
// Holds the item, result, configuration and command types and fixed constants.
// No dependencies.
package bbd_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 13;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BLOCK_SHIFT  = 3'd0,
    CFG_ROI_LEFT     = 3'd1,
    CFG_ROI_TOP      = 3'd2,
    CFG_GRID_COLUMNS = 3'd3,
    CFG_GRID_ROWS    = 3'd4,
    CFG_FRAME_WIDTH  = 3'd5,
    CFG_FRAME_HEIGHT = 3'd6
  } cfg_index_t;

  localparam logic [2:0]  RESET_BLOCK_SHIFT  = 3'd3;
  localparam logic [11:0] RESET_ROI_LEFT     = 12'd0;
  localparam logic [11:0] RESET_ROI_TOP      = 12'd0;
  localparam logic [6:0]  RESET_GRID_COLUMNS = 7'd64;
  localparam logic [6:0]  RESET_GRID_ROWS    = 7'd64;
  localparam logic [12:0] RESET_FRAME_WIDTH  = 13'd512;
  localparam logic [12:0] RESET_FRAME_HEIGHT = 13'd512;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } colour_t;

  typedef struct packed {
    logic       op;
    logic [5:0] block_row;
    logic [5:0] block_col;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] difference;
    logic       frame_end;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  block_shift;
    logic [11:0] roi_left;
    logic [11:0] roi_top;
    logic [6:0]  grid_columns;
    logic [6:0]  grid_rows;
    logic [12:0] frame_width;
    logic [12:0] frame_height;
  } cfg_t;

  typedef struct packed {
    logic is_load;
    logic covered;
    logic frame_end;
  } cmd_ctl_t;

endpackage

FILE: src/bbd_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module bbd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/bbd_front.sv
// Front end: accepts items, keeps the raster counters and classifies each item.
// Produces a memory address and control flags per command. Uses bbd_pkg.
module bbd_front import bbd_pkg::*; #(
  parameter int GRID_MAX_SIDE = 64,
  parameter int COORD_BITS    = 12,
  parameter int AW            = 12
) (
  input  logic           clk,
  input  logic           rst,
  input  cfg_t           cfg,
  input  logic           item_valid,
  output logic           item_stall,
  input  in_item_t       item,
  input  logic           q_ready,
  output logic           cmd_valid,
  output cmd_ctl_t       cmd_ctl,
  output colour_t        cmd_colour,
  output logic [AW-1:0]  cmd_addr
);

  localparam int GB  = $clog2(GRID_MAX_SIDE);
  localparam int XW  = (COORD_BITS > 12) ? COORD_BITS : 12;
  localparam int GSW = ($clog2(GRID_MAX_SIDE + 1) > 7) ? $clog2(GRID_MAX_SIDE + 1) : 7;
  localparam int MW  = (XW > GSW) ? XW : GSW;
  localparam int CW  = (COORD_BITS + 1 > 13) ? COORD_BITS + 1 : 13;
  localparam logic [CW-1:0] SPAN = CW'(1) << COORD_BITS;

  logic [COORD_BITS-1:0] pixel_column, pixel_column_next;
  logic [COORD_BITS-1:0] pixel_row, pixel_row_next;
  logic [CW-1:0]         w, h;
  logic [GSW-1:0]        side_x, side_y;
  logic [GB-1:0]         bx, by;
  logic                  col_last, row_last, in_frame, load_ok, accept;

  function automatic logic [GB-1:0] block_index(input logic [XW-1:0] coord,
                                                input logic [XW-1:0] origin,
                                                input logic [GSW-1:0] side,
                                                input logic [2:0] shift);
    logic [XW-1:0] rel;
    logic [MW-1:0] rel_w;
    logic [MW-1:0] limit;
    logic [GB-1:0] idx;
    rel   = (coord - origin) >> shift;
    rel_w = MW'(rel);
    limit = MW'(side) - MW'(2);
    idx   = '0;
    if (side >= GSW'(3) && coord >= origin && rel_w < limit) begin
      idx = GB'(rel_w + MW'(1));
    end
    return idx;
  endfunction

  always_comb begin
    w = (cfg.frame_width == '0 || CW'(cfg.frame_width) > SPAN) ? SPAN : CW'(cfg.frame_width);
    h = (cfg.frame_height == '0 || CW'(cfg.frame_height) > SPAN) ? SPAN
        : CW'(cfg.frame_height);
    side_x = (GSW'(cfg.grid_columns) > GSW'(GRID_MAX_SIDE)) ? GSW'(GRID_MAX_SIDE)
             : GSW'(cfg.grid_columns);
    side_y = (GSW'(cfg.grid_rows) > GSW'(GRID_MAX_SIDE)) ? GSW'(GRID_MAX_SIDE)
             : GSW'(cfg.grid_rows);
    bx = block_index(XW'(pixel_column), XW'(cfg.roi_left), side_x, cfg.block_shift);
    by = block_index(XW'(pixel_row), XW'(cfg.roi_top), side_y, cfg.block_shift);
    col_last = CW'(pixel_column) >= w - CW'(1);
    row_last = CW'(pixel_row) >= h - CW'(1);
    in_frame = CW'(pixel_column) < w && CW'(pixel_row) < h;
    load_ok  = int'(item.block_row) < GRID_MAX_SIDE && int'(item.block_col) < GRID_MAX_SIDE;

    item_stall = !q_ready;
    accept     = item_valid && q_ready;

    cmd_colour = '{red: item.red, green: item.green, blue: item.blue};
    cmd_ctl    = '0;
    if (item.op == OP_LOAD) begin
      cmd_valid       = accept && load_ok;
      cmd_ctl.is_load = 1'b1;
      cmd_addr        = AW'(item.block_row) * AW'(GRID_MAX_SIDE) + AW'(item.block_col);
    end else begin
      cmd_valid         = accept;
      cmd_ctl.covered   = bx != '0 && by != '0 && in_frame;
      cmd_ctl.frame_end = col_last && row_last;
      cmd_addr          = AW'(by) * AW'(GRID_MAX_SIDE) + AW'(bx);
    end

    pixel_column_next = pixel_column;
    pixel_row_next    = pixel_row;
    if (accept && item.op == OP_PIXEL) begin
      if (col_last) begin
        pixel_column_next = '0;
        pixel_row_next    = row_last ? '0 : pixel_row + COORD_BITS'(1);
      end else begin
        pixel_column_next = pixel_column + COORD_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_column <= '0;
      pixel_row    <= '0;
    end else begin
      pixel_column <= pixel_column_next;
      pixel_row    <= pixel_row_next;
    end
  end

endmodule

FILE: src/bbd_queue.sv
// Short register queue that decouples the front end from the back end.
// Generic over entry width. No dependencies.
module bbd_queue #(
  parameter int WIDTH = 39,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             ready,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] data
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [NW-1:0]    count;

  assign ready = count != NW'(DEPTH);
  assign valid = count != '0;
  assign data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + NW'(push) - NW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> ready)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> valid)
    else $error("queue pop while empty");

endmodule

FILE: src/bbd_back.sv
// Back end: performs block memory loads and reads and computes the difference.
// Uses bbd_pkg and bbd_ram.
module bbd_back import bbd_pkg::*; #(
  parameter int GRID_MAX_SIDE = 64,
  parameter int AW            = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  cmd_ctl_t      q_ctl,
  input  colour_t       q_colour,
  input  logic [AW-1:0] q_addr,
  output logic          q_pop,
  output logic          result_valid,
  input  logic          result_stall,
  output out_item_t     result
);

  logic     ram_we, ram_re;
  colour_t  ram_rdata;
  logic     s1_valid, s1_go;
  cmd_ctl_t s1_ctl;
  colour_t  s1_colour;
  logic [7:0] diff;

  function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  always_comb begin
    logic [7:0] dr, dg, db;
    dr = absdiff(s1_colour.red, ram_rdata.red);
    dg = absdiff(s1_colour.green, ram_rdata.green);
    db = absdiff(s1_colour.blue, ram_rdata.blue);
    diff = dr;
    if (dg > diff) begin
      diff = dg;
    end
    if (db > diff) begin
      diff = db;
    end
    if (!s1_ctl.covered) begin
      diff = '0;
    end
  end

  assign s1_go  = s1_valid && (!result_valid || !result_stall);
  assign q_pop  = q_valid && (!s1_valid || s1_go);
  assign ram_we = q_pop && q_ctl.is_load;
  assign ram_re = q_pop && !q_ctl.is_load && q_ctl.covered;

  bbd_ram #(
    .WIDTH ($bits(colour_t)),
    .DEPTH (GRID_MAX_SIDE * GRID_MAX_SIDE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_addr),
    .wdata (q_colour),
    .re    (ram_re),
    .raddr (q_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_ctl    <= q_ctl;
      s1_colour <= q_colour;
    end
    if (s1_go) begin
      result.difference <= diff;
      result.frame_end  <= s1_ctl.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (q_pop && !q_ctl.is_load) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |=> s1_valid)
    else $error("pending pixel lost while output stalled");
  a_ram_exclusive: assert property (@(posedge clk) disable iff (rst) !(ram_we && ram_re))
    else $error("block memory written and read in one cycle");

endmodule

FILE: src/block_background_difference.sv
// Block background difference top level: configuration registers, front end, queue, back end.
// A pixel passes through the queue, the stage-one register and the result register; loads give no result.
// Throughput: one item per cycle unless the queue is full; each item does at most one block memory read or write.
// Reset (synchronous): configuration to defaults, raster counters, queue and valid flags clear.
// The block colour memory is not cleared; there is no clearing pass after reset.
module block_background_difference import bbd_pkg::*; #(
  parameter int GRID_MAX_SIDE = 64,
  parameter int COORD_BITS    = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  in_item_t               item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output out_item_t              result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = $clog2(GRID_MAX_SIDE * GRID_MAX_SIDE);
  localparam int QW = $bits(cmd_ctl_t) + $bits(colour_t) + AW;

  cfg_t          cfg;
  logic          q_ready, q_valid, q_pop, cmd_valid;
  cmd_ctl_t      cmd_ctl, q_ctl;
  colour_t       cmd_colour, q_colour;
  logic [AW-1:0] cmd_addr, q_addr;
  logic [QW-1:0] q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_shift  <= RESET_BLOCK_SHIFT;
      cfg.roi_left     <= RESET_ROI_LEFT;
      cfg.roi_top      <= RESET_ROI_TOP;
      cfg.grid_columns <= RESET_GRID_COLUMNS;
      cfg.grid_rows    <= RESET_GRID_ROWS;
      cfg.frame_width  <= RESET_FRAME_WIDTH;
      cfg.frame_height <= RESET_FRAME_HEIGHT;
    end else if (cfg_write) begin
      case (cfg_index_t'(cfg_index))
        CFG_BLOCK_SHIFT:  cfg.block_shift  <= cfg_data[2:0];
        CFG_ROI_LEFT:     cfg.roi_left     <= cfg_data[11:0];
        CFG_ROI_TOP:      cfg.roi_top      <= cfg_data[11:0];
        CFG_GRID_COLUMNS: cfg.grid_columns <= cfg_data[6:0];
        CFG_GRID_ROWS:    cfg.grid_rows    <= cfg_data[6:0];
        CFG_FRAME_WIDTH:  cfg.frame_width  <= cfg_data[12:0];
        CFG_FRAME_HEIGHT: cfg.frame_height <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  bbd_front #(
    .GRID_MAX_SIDE (GRID_MAX_SIDE),
    .COORD_BITS    (COORD_BITS),
    .AW            (AW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_ready    (q_ready),
    .cmd_valid  (cmd_valid),
    .cmd_ctl    (cmd_ctl),
    .cmd_colour (cmd_colour),
    .cmd_addr   (cmd_addr)
  );

  bbd_queue #(
    .WIDTH (QW),
    .DEPTH (4)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_valid),
    .push_data ({cmd_ctl, cmd_colour, cmd_addr}),
    .ready     (q_ready),
    .pop       (q_pop),
    .valid     (q_valid),
    .data      (q_data)
  );

  assign {q_ctl, q_colour, q_addr} = q_data;

  bbd_back #(
    .GRID_MAX_SIDE (GRID_MAX_SIDE),
    .AW            (AW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_ctl        (q_ctl),
    .q_colour     (q_colour),
    .q_addr       (q_addr),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
